[hw/rtl/point_in_tetrahedron_test_defines.svh]
// Assertion macros shared by the point-in-tetrahedron RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef POINT_IN_TETRAHEDRON_TEST_DEFINES_SVH
`define POINT_IN_TETRAHEDRON_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PITT_ASSERT_SAME(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PITT_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pitt_pkg.sv]
// Types and constants for the point-in-tetrahedron classifier.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package pitt_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int POINT_WIDTH = 48;
    localparam int TAG_WIDTH   = 16;
    localparam int NUM_FACES   = 4;
    localparam int PACK_WIDTH  = 3 * COORD_WIDTH;

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
    localparam int NORM_WIDTH = PROD_WIDTH + 1;
    localparam int DOT_WIDTH  = NORM_WIDTH + DIFF_WIDTH;
    localparam int SUM_WIDTH  = DOT_WIDTH + 2;

    typedef logic [POINT_WIDTH-1:0]        point_t;
    typedef logic [TAG_WIDTH-1:0]          tag_t;
    typedef logic [NUM_FACES-1:0]          flags_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [NORM_WIDTH-1:0]  norm_t;
    typedef logic signed [DOT_WIDTH-1:0]   dot_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
        diff_t z;
    } dvec_t;

    typedef struct packed {
        norm_t x;
        norm_t y;
        norm_t z;
    } nvec_t;

    // Edge vectors of one face and the vectors to the opposite vertex and the point.
    typedef struct packed {
        dvec_t e2;
        dvec_t e3;
        dvec_t to_opp;
        dvec_t to_pt;
    } face_diff_t;

    // The six partial products of the face normal, with the vectors to the opposite vertex and the point.
    typedef struct packed {
        prod_t yz;
        prod_t zy;
        prod_t zx;
        prod_t xz;
        prod_t xy;
        prod_t yx;
        dvec_t to_opp;
        dvec_t to_pt;
    } face_cross_t;

    typedef struct packed {
        nvec_t normal;
        dvec_t to_opp;
        dvec_t to_pt;
    } face_norm_t;

    typedef struct packed {
        dot_t opp_x;
        dot_t opp_y;
        dot_t opp_z;
        dot_t pt_x;
        dot_t pt_y;
        dot_t pt_z;
    } face_dot_t;

    // Coordinate idx of a packed point; bits above the point read as zero.
    function automatic coord_t coord_at(point_t point, int idx);
        logic [PACK_WIDTH-1:0] ext;
        begin
            ext = PACK_WIDTH'(point);
            return coord_t'(ext[idx*COORD_WIDTH +: COORD_WIDTH]);
        end
    endfunction

    function automatic dvec_t vec_sub(point_t a, point_t b);
        dvec_t r;
        begin
            r.x = DIFF_WIDTH'(coord_at(a, 0)) - DIFF_WIDTH'(coord_at(b, 0));
            r.y = DIFF_WIDTH'(coord_at(a, 1)) - DIFF_WIDTH'(coord_at(b, 1));
            r.z = DIFF_WIDTH'(coord_at(a, 2)) - DIFF_WIDTH'(coord_at(b, 2));
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pitt_if.sv]
// Valid/ready channel interfaces for queries and results of the classifier.
// Depends on pitt_pkg for the payload types.
`default_nettype none

interface pitt_query_if;
    logic              valid;
    logic              ready;
    pitt_pkg::point_t  vertex_a;
    pitt_pkg::point_t  vertex_b;
    pitt_pkg::point_t  vertex_c;
    pitt_pkg::point_t  vertex_d;
    pitt_pkg::point_t  query_point;
    pitt_pkg::tag_t    cell_tag;

    modport source (
        output valid, vertex_a, vertex_b, vertex_c, vertex_d, query_point, cell_tag,
        input  ready
    );
    modport sink (
        input  valid, vertex_a, vertex_b, vertex_c, vertex_d, query_point, cell_tag,
        output ready
    );
endinterface

interface pitt_result_if;
    logic              valid;
    logic              ready;
    logic              inside_res;
    pitt_pkg::flags_t  face_flags;
    pitt_pkg::tag_t    result_tag;

    modport source (
        output valid, inside_res, face_flags, result_tag,
        input  ready
    );
    modport sink (
        input  valid, inside_res, face_flags, result_tag,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/point_in_tetrahedron_test.sv]
// Point-in-tetrahedron classifier, five-stage pipeline.
// Depends on pitt_pkg, the channel interfaces in pitt_if.sv and the assertion macros.
//
// Usage: each beat on the query channel carries the four vertices of a tetrahedron,
// a query point and a tag; each point packs x, y and z as signed fixed-point
// coordinates. For every accepted query exactly one beat leaves on the result
// channel, in order, with one flag per face, their AND as inside_res and the tag.
// A point on a face plane passes that face, and every face of a flat tetrahedron passes.
// An accepted query is registered in stage 1 and moves through stages 2, 3 and 4 to
// the output register. Throughput: one query per cycle while the result channel takes
// results; the cross and dot products are combinational multipliers in stages 2 and 4.
// Each stage holds its own valid bit and loads when it is empty or moves on, so a
// stall on the result channel first fills any empty stages and only then drops
// ready on the query channel; no beat is lost or repeated.
// Reset clears the valid bits only; the data, tag and flag registers are not reset.
`default_nettype none
`include "point_in_tetrahedron_test_defines.svh"

module point_in_tetrahedron_test (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pitt_query_if.sink     query,
    pitt_result_if.source  result
);

    localparam int NF = pitt_pkg::NUM_FACES;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    pitt_pkg::face_diff_t  s1_reg [NF];
    pitt_pkg::face_diff_t  s1_next [NF];
    pitt_pkg::face_cross_t s2_reg [NF];
    pitt_pkg::face_cross_t s2_next [NF];
    pitt_pkg::face_norm_t  s3_reg [NF];
    pitt_pkg::face_norm_t  s3_next [NF];
    pitt_pkg::face_dot_t   s4_reg [NF];
    pitt_pkg::face_dot_t   s4_next [NF];
    pitt_pkg::tag_t        tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag_out_reg;
    pitt_pkg::flags_t      flags_next, flags_reg;
    logic                  inside_reg;

    pitt_pkg::point_t verts [NF];

    assign ld5 = !out_valid_reg || result.ready;
    assign ld4 = !s4_valid_reg || ld5;
    assign ld3 = !s3_valid_reg || ld4;
    assign ld2 = !s2_valid_reg || ld3;
    assign ld1 = !s1_valid_reg || ld2;
    assign query.ready = ld1;

    // Stage 1: edge vectors and the vectors to the opposite vertex and the point, from each face's first vertex.
    always_comb
    begin
        verts[0] = query.vertex_a;
        verts[1] = query.vertex_b;
        verts[2] = query.vertex_c;
        verts[3] = query.vertex_d;
        for (int f = 0; f < NF; f++)
        begin
            s1_next[f].e2     = pitt_pkg::vec_sub(verts[2'(f + 1)], verts[2'(f)]);
            s1_next[f].e3     = pitt_pkg::vec_sub(verts[2'(f + 2)], verts[2'(f)]);
            s1_next[f].to_opp = pitt_pkg::vec_sub(verts[2'(f + 3)], verts[2'(f)]);
            s1_next[f].to_pt  = pitt_pkg::vec_sub(query.query_point, verts[2'(f)]);
        end
    end

    // Stage 2: partial products of the cross product.
    always_comb
    begin
        for (int f = 0; f < NF; f++)
        begin
            s2_next[f].yz = pitt_pkg::PROD_WIDTH'(s1_reg[f].e2.y)
                          * pitt_pkg::PROD_WIDTH'(s1_reg[f].e3.z);
            s2_next[f].zy = pitt_pkg::PROD_WIDTH'(s1_reg[f].e2.z)
                          * pitt_pkg::PROD_WIDTH'(s1_reg[f].e3.y);
            s2_next[f].zx = pitt_pkg::PROD_WIDTH'(s1_reg[f].e2.z)
                          * pitt_pkg::PROD_WIDTH'(s1_reg[f].e3.x);
            s2_next[f].xz = pitt_pkg::PROD_WIDTH'(s1_reg[f].e2.x)
                          * pitt_pkg::PROD_WIDTH'(s1_reg[f].e3.z);
            s2_next[f].xy = pitt_pkg::PROD_WIDTH'(s1_reg[f].e2.x)
                          * pitt_pkg::PROD_WIDTH'(s1_reg[f].e3.y);
            s2_next[f].yx = pitt_pkg::PROD_WIDTH'(s1_reg[f].e2.y)
                          * pitt_pkg::PROD_WIDTH'(s1_reg[f].e3.x);
            s2_next[f].to_opp = s1_reg[f].to_opp;
            s2_next[f].to_pt  = s1_reg[f].to_pt;
        end
    end

    // Stage 3: the face normal.
    always_comb
    begin
        for (int f = 0; f < NF; f++)
        begin
            s3_next[f].normal.x = pitt_pkg::NORM_WIDTH'(s2_reg[f].yz)
                                - pitt_pkg::NORM_WIDTH'(s2_reg[f].zy);
            s3_next[f].normal.y = pitt_pkg::NORM_WIDTH'(s2_reg[f].zx)
                                - pitt_pkg::NORM_WIDTH'(s2_reg[f].xz);
            s3_next[f].normal.z = pitt_pkg::NORM_WIDTH'(s2_reg[f].xy)
                                - pitt_pkg::NORM_WIDTH'(s2_reg[f].yx);
            s3_next[f].to_opp = s2_reg[f].to_opp;
            s3_next[f].to_pt  = s2_reg[f].to_pt;
        end
    end

    // Stage 4: products of the two dot products.
    always_comb
    begin
        for (int f = 0; f < NF; f++)
        begin
            s4_next[f].opp_x = pitt_pkg::DOT_WIDTH'(s3_reg[f].normal.x)
                             * pitt_pkg::DOT_WIDTH'(s3_reg[f].to_opp.x);
            s4_next[f].opp_y = pitt_pkg::DOT_WIDTH'(s3_reg[f].normal.y)
                             * pitt_pkg::DOT_WIDTH'(s3_reg[f].to_opp.y);
            s4_next[f].opp_z = pitt_pkg::DOT_WIDTH'(s3_reg[f].normal.z)
                             * pitt_pkg::DOT_WIDTH'(s3_reg[f].to_opp.z);
            s4_next[f].pt_x  = pitt_pkg::DOT_WIDTH'(s3_reg[f].normal.x)
                             * pitt_pkg::DOT_WIDTH'(s3_reg[f].to_pt.x);
            s4_next[f].pt_y  = pitt_pkg::DOT_WIDTH'(s3_reg[f].normal.y)
                             * pitt_pkg::DOT_WIDTH'(s3_reg[f].to_pt.y);
            s4_next[f].pt_z  = pitt_pkg::DOT_WIDTH'(s3_reg[f].normal.z)
                             * pitt_pkg::DOT_WIDTH'(s3_reg[f].to_pt.z);
        end
    end

    // Stage 5: sums, signs and the same-side decision.
    always_comb
    begin
        pitt_pkg::sum_t sum_opp;
        pitt_pkg::sum_t sum_pt;
        logic opp_pos, opp_neg, pt_pos, pt_neg;
        flags_next = '0;
        for (int f = 0; f < NF; f++)
        begin
            sum_opp = pitt_pkg::SUM_WIDTH'(s4_reg[f].opp_x)
                    + pitt_pkg::SUM_WIDTH'(s4_reg[f].opp_y)
                    + pitt_pkg::SUM_WIDTH'(s4_reg[f].opp_z);
            sum_pt  = pitt_pkg::SUM_WIDTH'(s4_reg[f].pt_x)
                    + pitt_pkg::SUM_WIDTH'(s4_reg[f].pt_y)
                    + pitt_pkg::SUM_WIDTH'(s4_reg[f].pt_z);
            opp_neg = sum_opp[pitt_pkg::SUM_WIDTH-1];
            opp_pos = !opp_neg && (|sum_opp);
            pt_neg  = sum_pt[pitt_pkg::SUM_WIDTH-1];
            pt_pos  = !pt_neg && (|sum_pt);
            flags_next[f] = !((opp_pos && pt_neg) || (opp_neg && pt_pos));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_valid_reg <= query.valid;
            end
            if (ld2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ld3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ld4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (ld5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && query.valid)
        begin
            s1_reg   <= s1_next;
            tag1_reg <= query.cell_tag;
        end
        if (ld2 && s1_valid_reg)
        begin
            s2_reg   <= s2_next;
            tag2_reg <= tag1_reg;
        end
        if (ld3 && s2_valid_reg)
        begin
            s3_reg   <= s3_next;
            tag3_reg <= tag2_reg;
        end
        if (ld4 && s3_valid_reg)
        begin
            s4_reg   <= s4_next;
            tag4_reg <= tag3_reg;
        end
        if (ld5 && s4_valid_reg)
        begin
            flags_reg   <= flags_next;
            inside_reg  <= &flags_next;
            tag_out_reg <= tag4_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.inside_res = inside_reg;
    assign result.face_flags = flags_reg;
    assign result.result_tag = tag_out_reg;

    `PITT_ASSERT_SAME(a_inside_is_and, clk, rst_n, out_valid_reg,
        inside_reg == (&flags_reg), "inside_res differs from the AND of the face flags")
    `PITT_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, query.valid && query.ready,
        s1_valid_reg, "an accepted beat did not reach the first stage")
    `PITT_ASSERT_NEXT(a_s4_holds_on_stall, clk, rst_n, s4_valid_reg && !ld5,
        s4_valid_reg, "last stage lost its beat during a stall")
    `PITT_ASSERT_SAME(a_full_pipe_blocks, clk, rst_n,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && !ld5,
        !query.ready, "query accepted while every stage is full and stalled")

endmodule

`default_nettype wire

[bench/point_in_tetrahedron_test_test.sv]
// Self-checking bench for the point-in-tetrahedron classifier: random queries, shaped
// tetrahedra and stalls on both channels, with an in-order check against exact arithmetic.
// Depends on pitt_pkg, the channel interfaces in pitt_if.sv and the classifier RTL.

module point_in_tetrahedron_test_test;

    import pitt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int CMAX = 2 ** (CW - 1) - 1;
    localparam int CMIN = -(2 ** (CW - 1));
    localparam int RANDOM_QUERIES = 1130;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef logic signed [95:0] wide_t;

    typedef struct {
        wide_t x;
        wide_t y;
        wide_t z;
    } vec_t;

    typedef struct packed {
        point_t a;
        point_t b;
        point_t c;
        point_t d;
        point_t pt;
        tag_t   tag;
    } query_beat_t;

    typedef struct packed {
        logic   in_tet;
        flags_t flags;
        tag_t   tag;
    } verdict_t;

    logic clk;
    logic rst_n;

    pitt_query_if  query_ch ();
    pitt_result_if result_ch ();

    point_in_tetrahedron_test DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    query_beat_t queries_pending [$];
    verdict_t    verdicts_due [$];
    query_beat_t on_wire;
    int          queries_planned;
    int          queries_accepted = 0;
    int          results_seen = 0;
    int          faults = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          cycles = 0;

    function automatic wide_t coord_of(point_t p, int idx);
        logic [3*CW-1:0]       ext;
        logic signed [CW-1:0]  raw;
        ext = (3 * CW)'(p);
        raw = ext[idx*CW +: CW];
        return wide_t'(raw);
    endfunction

    function automatic vec_t as_vector(point_t p);
        vec_t v;
        v.x = coord_of(p, 0);
        v.y = coord_of(p, 1);
        v.z = coord_of(p, 2);
        return v;
    endfunction

    function automatic vec_t vdiff(vec_t u, vec_t v);
        vec_t r;
        r.x = u.x - v.x;
        r.y = u.y - v.y;
        r.z = u.z - v.z;
        return r;
    endfunction

    function automatic int side_of(vec_t n, vec_t v);
        wide_t s;
        s = n.x * v.x + n.y * v.y + n.z * v.z;
        return (s > 0) ? 1 : ((s < 0) ? -1 : 0);
    endfunction

    function automatic logic face_holds(vec_t p1, vec_t p2, vec_t p3, vec_t opp, vec_t pt);
        vec_t e2, e3, n;
        int   so, sp;
        e2 = vdiff(p2, p1);
        e3 = vdiff(p3, p1);
        n.x = e2.y * e3.z - e2.z * e3.y;
        n.y = e2.z * e3.x - e2.x * e3.z;
        n.z = e2.x * e3.y - e2.y * e3.x;
        so = side_of(n, vdiff(opp, p1));
        sp = side_of(n, vdiff(pt, p1));
        return !((so > 0 && sp < 0) || (so < 0 && sp > 0));
    endfunction

    function automatic verdict_t classify(query_beat_t q);
        vec_t     a, b, c, d, p;
        verdict_t v;
        a = as_vector(q.a);
        b = as_vector(q.b);
        c = as_vector(q.c);
        d = as_vector(q.d);
        p = as_vector(q.pt);
        v.flags[0] = face_holds(a, b, c, d, p);
        v.flags[1] = face_holds(b, c, d, a, p);
        v.flags[2] = face_holds(c, d, a, b, p);
        v.flags[3] = face_holds(d, a, b, c, p);
        v.in_tet = &v.flags;
        v.tag = q.tag;
        return v;
    endfunction

    function automatic point_t pack_point(int x, int y, int z);
        logic [3*CW-1:0] bits;
        bits = {CW'(z), CW'(y), CW'(x)};
        return point_t'(bits);
    endfunction

    function automatic point_t raw_point();
        return point_t'({$urandom, $urandom});
    endfunction

    function automatic void add_query(point_t a, point_t b, point_t c, point_t d,
                                      point_t pt, tag_t tag);
        query_beat_t q;
        q.a = a;
        q.b = b;
        q.c = c;
        q.d = d;
        q.pt = pt;
        q.tag = tag;
        queries_pending.push_back(q);
    endfunction

    // Pauses are mostly short with the odd long one; every third stretch of 200 beats has none.
    function automatic int pause_len(int beats);
        int roll;
        if ((beats / 200) % 3 == 1)
        begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    function automatic void add_directed_queries();
        point_t o, ex, ey, ez;
        o  = pack_point(0, 0, 0);
        ex = pack_point(100, 0, 0);
        ey = pack_point(0, 100, 0);
        ez = pack_point(0, 0, 100);
        add_query(o, o, o, o, o, 16'h0000);
        add_query(o, ex, ey, ez, pack_point(10, 10, 10), 16'hFFFF);
        add_query(o, ey, ex, ez, pack_point(20, 30, 40), 16'h0001);
        add_query(o, ex, ey, ez, pack_point(-1, 10, 10), 16'h0002);
        add_query(o, ex, ey, ez, pack_point(10, -1, 10), 16'h0004);
        add_query(o, ex, ey, ez, pack_point(10, 10, -1), 16'h0008);
        add_query(o, ex, ey, ez, pack_point(50, 50, 50), 16'h0010);
        // Points on a face plane, at a vertex, and on a plane but beyond the triangle.
        add_query(o, ex, ey, ez, pack_point(0, 10, 10), 16'h0020);
        add_query(o, ex, ey, ez, pack_point(34, 33, 33), 16'h0040);
        add_query(o, ex, ey, ez, ex, 16'h0080);
        add_query(o, ex, ey, ez, pack_point(0, -50, 200), 16'h0100);
        // Flat, collinear and repeated-vertex tetrahedra.
        add_query(o, ex, ey, pack_point(100, 100, 0), pack_point(7, -9, 300), 16'h0200);
        add_query(o, ex, pack_point(200, 0, 0), pack_point(-300, 0, 0),
                  pack_point(5, 5, 5), 16'h0400);
        add_query(ex, ex, ey, ez, pack_point(-40, 90, -20), 16'h0800);
        // Extreme coordinates, giving the largest normals and dot products.
        add_query(pack_point(CMIN, CMIN, CMIN), pack_point(CMAX, CMIN, CMIN),
                  pack_point(CMIN, CMAX, CMIN), pack_point(CMIN, CMIN, CMAX),
                  pack_point(-CW, -CW, -CW), 16'h1000);
        add_query(pack_point(CMIN, CMIN, CMIN), pack_point(CMAX, CMIN, CMIN),
                  pack_point(CMIN, CMAX, CMIN), pack_point(CMIN, CMIN, CMAX),
                  pack_point(CMAX, CMAX, CMAX), 16'h2000);
        add_query(pack_point(CMIN, CMIN, CMIN), pack_point(CMAX, CMIN, CMIN),
                  pack_point(CMIN, CMAX, CMIN), pack_point(CMIN, CMIN, CMAX),
                  pack_point(CMIN, CMIN, CMIN), 16'h4000);
        add_query(pack_point(CMAX, CMIN, CMAX), pack_point(CMIN, CMAX, CMIN),
                  pack_point(CMAX, CMAX, CMIN), pack_point(CMIN, CMIN, CMAX),
                  pack_point(CMIN, CMAX, CMAX), 16'h8000);
        add_query(pack_point(CMAX, CMAX, CMIN), pack_point(CMIN, CMAX, CMAX),
                  pack_point(CMAX, CMIN, CMAX), pack_point(CMIN, CMIN, CMIN),
                  pack_point(0, 0, 0), 16'h7FFF);
        // Raw bit patterns across the whole packed field.
        add_query('1, '1, '1, '1, '1, 16'hAAAA);
        add_query({(POINT_WIDTH/2){2'b10}}, {(POINT_WIDTH/2){2'b01}},
                  {(POINT_WIDTH/4){4'b1100}}, {(POINT_WIDTH/4){4'b0011}},
                  '0, 16'h5555);
        add_query({(POINT_WIDTH/2){2'b01}}, {(POINT_WIDTH/4){4'b0011}},
                  {(POINT_WIDTH/2){2'b10}}, '1, {(POINT_WIDTH/4){4'b1100}}, 16'hC3C3);
    endfunction

    function automatic void add_random_query();
        int v [5][3];
        int w [4];
        int m, lo, hi, centre, roll, wsum, s, t, f, i, j;
        m = (1 << $urandom_range(CW - 1, 1)) - 1;
        for (j = 0; j < 3; j++)
        begin
            lo = CMIN + m;
            hi = CMAX - m;
            centre = lo + int'($urandom_range(hi - lo));
            for (i = 0; i < 5; i++)
            begin
                v[i][j] = centre + int'($urandom_range(2 * m)) - m;
            end
        end
        roll = $urandom_range(99);
        if (roll < 35)
        begin
            wsum = 0;
            for (i = 0; i < 4; i++)
            begin
                w[i] = $urandom_range(8);
                wsum += w[i];
            end
            if (wsum == 0)
            begin
                w[0] = 1;
                wsum = 1;
            end
            for (j = 0; j < 3; j++)
            begin
                v[4][j] = (w[0] * v[0][j] + w[1] * v[1][j] + w[2] * v[2][j]
                           + w[3] * v[3][j]) / wsum;
            end
        end
        else if (roll < 50)
        begin
            f = $urandom_range(3);
            s = int'($urandom_range(4)) - 2;
            t = int'($urandom_range(4)) - 2;
            for (j = 0; j < 3; j++)
            begin
                v[4][j] = v[f][j] + s * (v[(f + 1) % 4][j] - v[f][j])
                          + t * (v[(f + 2) % 4][j] - v[f][j]);
            end
        end
        else if (roll < 60)
        begin
            f = $urandom_range(3);
            s = int'($urandom_range(4)) - 2;
            t = int'($urandom_range(4)) - 2;
            for (j = 0; j < 3; j++)
            begin
                v[f][j] = v[(f + 1) % 4][j]
                          + s * (v[(f + 2) % 4][j] - v[(f + 1) % 4][j])
                          + t * (v[(f + 3) % 4][j] - v[(f + 1) % 4][j]);
            end
        end
        if (roll < 80)
        begin
            add_query(pack_point(v[0][0], v[0][1], v[0][2]),
                      pack_point(v[1][0], v[1][1], v[1][2]),
                      pack_point(v[2][0], v[2][1], v[2][2]),
                      pack_point(v[3][0], v[3][1], v[3][2]),
                      pack_point(v[4][0], v[4][1], v[4][2]),
                      tag_t'($urandom));
        end
        else
        begin
            add_query(raw_point(), raw_point(), raw_point(), raw_point(), raw_point(),
                      tag_t'($urandom));
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            query_ch.valid <= 1'b0;
        end
        else
        begin
            if (query_ch.valid && query_ch.ready)
            begin
                verdicts_due.push_back(classify(on_wire));
                queries_accepted++;
                send_gap = pause_len(queries_accepted);
            end
            if (!(query_ch.valid && !query_ch.ready))
            begin
                if (send_gap > 0 || queries_pending.size() == 0)
                begin
                    if (send_gap > 0)
                    begin
                        send_gap--;
                    end
                    query_ch.valid <= 1'b0;
                end
                else
                begin
                    on_wire = queries_pending.pop_front();
                    query_ch.valid       <= 1'b1;
                    query_ch.vertex_a    <= on_wire.a;
                    query_ch.vertex_b    <= on_wire.b;
                    query_ch.vertex_c    <= on_wire.c;
                    query_ch.vertex_d    <= on_wire.d;
                    query_ch.query_point <= on_wire.pt;
                    query_ch.cell_tag    <= on_wire.tag;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t seen, want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen.in_tet = result_ch.inside_res;
                seen.flags = result_ch.face_flags;
                seen.tag = result_ch.result_tag;
                if (verdicts_due.size() == 0)
                begin
                    faults++;
                    if (faults <= REPORT_LIMIT)
                    begin
                        $display("result beat %0d unexpected: inside %0b flags %b tag %h",
                                 results_seen, seen.in_tet, seen.flags, seen.tag);
                    end
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (want.in_tet !== seen.in_tet || want.flags !== seen.flags
                        || want.tag !== seen.tag)
                    begin
                        faults++;
                        if (faults <= REPORT_LIMIT)
                        begin
                            $display("beat %0d exp/act: inside %0b/%0b flags %b/%b tag %h/%h",
                                     results_seen, want.in_tet, seen.in_tet, want.flags,
                                     seen.flags, want.tag, seen.tag);
                        end
                    end
                end
                results_seen++;
                stall_left = pause_len(results_seen);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("** point_in_tetrahedron_test: FAILED **");
        $finish;
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        query_ch.valid = 1'b0;
        query_ch.vertex_a = '0;
        query_ch.vertex_b = '0;
        query_ch.vertex_c = '0;
        query_ch.vertex_d = '0;
        query_ch.query_point = '0;
        query_ch.cell_tag = '0;
        result_ch.ready = 1'b0;
        add_directed_queries();
        for (n = 0; n < RANDOM_QUERIES; n++)
        begin
            add_random_query();
        end
        queries_planned = queries_pending.size();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (queries_accepted < queries_planned)
        begin
            @(posedge clk);
        end
        while (verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (faults == 0 && verdicts_due.size() == 0)
        begin
            $display("** point_in_tetrahedron_test: PASSED **");
        end
        else
        begin
            $display("** point_in_tetrahedron_test: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pitt_pkg.sv
hw/rtl/pitt_if.sv
hw/rtl/point_in_tetrahedron_test.sv
bench/point_in_tetrahedron_test_test.sv
